// File: hw/rtl/dtq_pkg.sv
package dtq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int OP_W      = 2;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_SCHEDULE = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_TICK     = 2'd2
	} op_e_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// one queue entry as it moves along the chain
	typedef struct packed {
		logic              vld;
		logic [TIME_W-1:0] dl;
		logic [ID_W-1:0]   id;
	} entry_t;

	localparam entry_t ENT_EMPTY = '{vld: 1'b0, dl: '0, id: '0};

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic eval;    // transfer accepted: latch compare flags
		logic ins;     // insert new entry this cycle
		logic cancel;  // cancel removal this cycle
	} ctl_t;

endpackage

// File: hw/rtl/dtq_cell.sv
module dtq_cell #(
	parameter int SLOT_W = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dtq_pkg::ctl_t            ctl,
	input  logic [dtq_pkg::TIME_W-1:0] key_dl,
	input  logic [dtq_pkg::ID_W-1:0] key_id,
	input  dtq_pkg::entry_t          new_ent,
	input  logic [SLOT_W-1:0]        new_slot,
	input  logic [SLOT_W-1:0]        pick,
	input  dtq_pkg::entry_t          left_ent,
	input  logic [SLOT_W-1:0]        left_slot,
	input  logic                     left_gt,
	input  logic                     left_rm,
	input  dtq_pkg::entry_t          right_ent,
	input  logic [SLOT_W-1:0]        right_slot,
	output dtq_pkg::entry_t          ent,
	output logic [SLOT_W-1:0]        slot,
	output logic                     gt,
	output logic                     rm,
	output logic                     match
);

	logic                       vld_q;
	logic [dtq_pkg::TIME_W-1:0] dl_q;
	logic [dtq_pkg::ID_W-1:0]   id_q;
	logic [SLOT_W-1:0]          slot_q;
	logic                       gt_q;
	logic                       match_q;
	logic                       take_left;
	logic                       take_new;
	logic                       take_right;
	dtq_pkg::entry_t            nxt_ent;
	logic [SLOT_W-1:0]          nxt_slot;

	assign ent   = '{vld: vld_q, dl: dl_q, id: id_q};
	assign slot  = slot_q;
	assign gt    = gt_q;
	assign match = vld_q && (id_q == key_id);

	// removal point ripples toward the tail
	assign rm = left_rm | (ctl.cancel && match_q && (slot_q == pick));

	// entries later than the new deadline move one cell back; equal ones stay ahead
	assign take_left  = ctl.ins && gt_q && left_gt;
	assign take_new   = ctl.ins && gt_q && !left_gt;
	assign take_right = !ctl.ins && rm;

	always_comb begin
		nxt_ent  = ent;
		nxt_slot = slot_q;
		if (take_left) begin
			nxt_ent  = left_ent;
			nxt_slot = left_slot;
		end else if (take_new) begin
			nxt_ent  = new_ent;
			nxt_slot = new_slot;
		end else if (take_right) begin
			nxt_ent  = right_ent;
			nxt_slot = right_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			gt_q    <= 1'b0;
			match_q <= 1'b0;
		end else begin
			vld_q <= nxt_ent.vld;
			if (ctl.eval) begin
				gt_q    <= !vld_q || (dl_q > key_dl);
				match_q <= match;
			end
		end
	end

	always_ff @(posedge clk) begin
		dl_q   <= nxt_ent.dl;
		id_q   <= nxt_ent.id;
		slot_q <= nxt_slot;
	end

endmodule

// File: hw/rtl/deadline_task_queue.sv
// Deadline-ordered task queue built as a sorted chain of QUEUE_DEPTH cells.
// Cell 0 always holds the live task with the earliest deadline; among equal
// deadlines the task scheduled first sits nearer the head. Every transfer on
// the slave side carries an operation in tuser (0 schedule, 1 cancel, 2 tick,
// 3 does nothing) and produces exactly one transfer on the master side.
// Schedule returns a fresh id (1 upward, 0 skipped on wrap) or 0 with accepted
// low when all slots are taken. Cancel reports accepted when a live task with
// that id was removed; with duplicate ids after wrap, the task in the lowest
// numbered storage slot goes first. Tick releases the head task if its
// deadline is <= now, reporting its id with fired high. Each item goes through
// an accept cycle and an update state: in the accept cycle every cell compares
// its entry against the incoming keys and latches the result; in the update
// state, once the output register can take the result, the entries behind the
// insert or removal point shift one place and the result is registered. Only
// then is the next item taken; a stalled output holds off the update.
module deadline_task_queue #(
	parameter int QUEUE_DEPTH = dtq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] deadline, [63:32] cancel_id, [95:64] now
	input  logic [dtq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] op
	input  logic [dtq_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] task_id_out, [32] accepted, [33] fired, [39:34] zero
	output logic [dtq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [dtq_pkg::ID_W-1:0] ID_LAST = '1;
	localparam logic [dtq_pkg::ID_W-1:0] ID_FIRST = dtq_pkg::ID_W'(1);

	// slave-side field split
	logic [dtq_pkg::TIME_W-1:0] in_deadline;
	logic [dtq_pkg::ID_W-1:0]   in_cancel_id;
	logic [dtq_pkg::TIME_W-1:0] in_now;

	assign in_deadline  = s_axis_tdata[31:0];
	assign in_cancel_id = s_axis_tdata[63:32];
	assign in_now       = s_axis_tdata[95:64];

	dtq_pkg::state_t state_q, state_nxt;
	logic            in_xfer;
	logic            exec_go;

	dtq_pkg::op_e_t             op_q;
	logic [dtq_pkg::TIME_W-1:0] deadline_q;
	logic [dtq_pkg::ID_W-1:0]   next_id_q;
	logic [QUEUE_DEPTH-1:0]     slot_used_q;
	logic [QUEUE_DEPTH-1:0]     hit_vec_q;
	logic [QUEUE_DEPTH-1:0]     hit_vec;
	logic                       due_q;

	logic                       out_vld_q;
	logic [dtq_pkg::ID_W-1:0]   out_id_q;
	logic                       out_acc_q;
	logic                       out_fired_q;

	// chain wiring
	dtq_pkg::entry_t        ent_c   [QUEUE_DEPTH];
	logic [SLOT_W-1:0]      slot_c  [QUEUE_DEPTH];
	dtq_pkg::entry_t        l_ent   [QUEUE_DEPTH];
	logic [SLOT_W-1:0]      l_slot  [QUEUE_DEPTH];
	dtq_pkg::entry_t        r_ent   [QUEUE_DEPTH];
	logic [SLOT_W-1:0]      r_slot  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt_c;
	logic [QUEUE_DEPTH-1:0] rm_c;
	logic [QUEUE_DEPTH-1:0] match_c;
	logic [QUEUE_DEPTH-1:0] l_gt;
	logic [QUEUE_DEPTH-1:0] l_rm;
	logic [QUEUE_DEPTH-1:0] cell_vld;

	dtq_pkg::ctl_t   ctl;
	dtq_pkg::entry_t new_ent;
	logic            full;
	logic            tick_fire;
	logic            cancel_hit;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] pick;

	logic [dtq_pkg::ID_W-1:0] res_id;
	logic                     res_acc;
	logic                     res_fired;

	// ---------------- handshake and sequencing ----------------
	assign s_axis_tready = (state_q == dtq_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	// chain update waits until the output register can take the result
	assign exec_go       = (state_q == dtq_pkg::ST_EXEC) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dtq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = dtq_pkg::ST_EXEC;
				end
			end
			dtq_pkg::ST_EXEC: begin
				if (exec_go) begin
					state_nxt = dtq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dtq_pkg::ST_IDLE;
		endcase
	end

	// ---------------- accept cycle: compares ----------------
	always_comb begin
		hit_vec = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (match_c[i]) begin
				hit_vec[slot_c[i]] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q       <= dtq_pkg::op_e_t'(s_axis_tuser);
			deadline_q <= in_deadline;
			hit_vec_q  <= hit_vec;
			due_q      <= ent_c[0].vld && (ent_c[0].dl <= in_now);
		end
	end

	// ---------------- update cycle ----------------
	assign full = &slot_used_q;

	// lowest free storage slot
	always_comb begin
		free_slot = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	// lowest storage slot holding the id to cancel
	always_comb begin
		pick = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (hit_vec_q[i]) begin
				pick = SLOT_W'(i);
			end
		end
	end

	assign cancel_hit = |hit_vec_q;
	assign tick_fire  = exec_go && (op_q == dtq_pkg::OP_TICK) && due_q;

	assign ctl.eval   = in_xfer;
	assign ctl.ins    = exec_go && (op_q == dtq_pkg::OP_SCHEDULE) && !full;
	assign ctl.cancel = exec_go && (op_q == dtq_pkg::OP_CANCEL);

	assign new_ent = '{vld: 1'b1, dl: deadline_q, id: next_id_q};

	always_comb begin
		res_id    = '0;
		res_acc   = 1'b0;
		res_fired = 1'b0;
		case (op_q)
			dtq_pkg::OP_SCHEDULE: begin
				res_acc = !full;
				res_id  = full ? '0 : next_id_q;
			end
			dtq_pkg::OP_CANCEL: begin
				res_acc = cancel_hit;
			end
			dtq_pkg::OP_TICK: begin
				res_fired = due_q;
				res_id    = due_q ? ent_c[0].id : '0;
			end
			default: begin
				res_id = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q   <= ID_FIRST;
			slot_used_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (ctl.ins) begin
				next_id_q              <= (next_id_q == ID_LAST) ? ID_FIRST : next_id_q + ID_FIRST;
				slot_used_q[free_slot] <= 1'b1;
			end else if (ctl.cancel && cancel_hit) begin
				slot_used_q[pick] <= 1'b0;
			end else if (tick_fire) begin
				slot_used_q[slot_c[0]] <= 1'b0;
			end
			if (exec_go) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_id_q    <= res_id;
			out_acc_q   <= res_acc;
			out_fired_q <= res_fired;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, out_fired_q, out_acc_q, out_id_q};

	// ---------------- cell chain ----------------
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign l_ent[g]  = dtq_pkg::ENT_EMPTY;
			assign l_slot[g] = '0;
			assign l_gt[g]   = 1'b0;
			assign l_rm[g]   = tick_fire;   // tick removes the head
		end else begin : g_mid
			assign l_ent[g]  = ent_c[g-1];
			assign l_slot[g] = slot_c[g-1];
			assign l_gt[g]   = gt_c[g-1];
			assign l_rm[g]   = rm_c[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign r_ent[g]  = dtq_pkg::ENT_EMPTY;
			assign r_slot[g] = '0;
		end else begin : g_body
			assign r_ent[g]  = ent_c[g+1];
			assign r_slot[g] = slot_c[g+1];
		end

		dtq_cell #(
			.SLOT_W(SLOT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_dl    (in_deadline),
			.key_id    (in_cancel_id),
			.new_ent   (new_ent),
			.new_slot  (free_slot),
			.pick      (pick),
			.left_ent  (l_ent[g]),
			.left_slot (l_slot[g]),
			.left_gt   (l_gt[g]),
			.left_rm   (l_rm[g]),
			.right_ent (r_ent[g]),
			.right_slot(r_slot[g]),
			.ent       (ent_c[g]),
			.slot      (slot_c[g]),
			.gt        (gt_c[g]),
			.rm        (rm_c[g]),
			.match     (match_c[g])
		);

		assign cell_vld[g] = ent_c[g].vld;
	end

	// ---------------- assertions ----------------
	// slot bookkeeping tracks the number of live cells
	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_used_q) == $countones(cell_vld))
		else $error("slot map and chain occupancy disagree");

	// the head cell is live whenever any cell is live
	a_head_live: assert property (@(posedge clk) disable iff (!arst_n)
		(|cell_vld) |-> cell_vld[0])
		else $error("chain has a hole at the head");

	// a new result appears only after an update cycle
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == dtq_pkg::ST_EXEC))
		else $error("result without update cycle");

	// a result never both accepts and fires
	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_acc_q && out_fired_q))
		else $error("accepted and fired together");

	// id counter never reaches zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> (next_id_q != '0))
		else $error("id counter hit zero");

endmodule
